FILE: rtl/scs_pkg.sv
// Shared types, character codes and decode tables of the source comment stripper.
package scs_pkg;

   // Code points are held at 26 bits: enough for any four-byte UTF-8 accumulation.
   localparam int CP_W      = 26;
   localparam int MAX_RES   = 3;
   localparam int RES_SLOTS = 4;

   typedef logic [CP_W-1:0] cp_type;

   // Configuration register indexes.
   localparam logic CSR_SOURCE_IS_UTF8 = 1'b0;
   localparam logic CSR_STRIP_COMMENTS = 1'b1;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BSTAR,
      MODE_STRING,
      MODE_ESC
   } scan_mode_type;

   localparam logic [1:0] QUOTE_NONE     = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE   = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE   = 2'd2;
   localparam logic [1:0] QUOTE_BACKTICK = 2'd3;

   localparam cp_type CP_LF        = 26'h0A;
   localparam cp_type CP_CR        = 26'h0D;
   localparam cp_type CP_DQUOTE    = 26'h22;
   localparam cp_type CP_SQUOTE    = 26'h27;
   localparam cp_type CP_STAR      = 26'h2A;
   localparam cp_type CP_SLASH     = 26'h2F;
   localparam cp_type CP_BACKSLASH = 26'h5C;
   localparam cp_type CP_BACKTICK  = 26'h60;
   localparam cp_type CP_LS        = 26'h2028;
   localparam cp_type CP_PS        = 26'h2029;

   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef struct packed {
      scan_mode_type scan_mode;
      logic [1:0]    open_quote;
      logic [7:0]    last_emitted;
      logic          any_emitted;
      cp_type        decode_acc;
      logic [1:0]    bytes_remaining;
      logic [2:0]    sequence_length;
      logic          cr_pending;
      logic          failed;
   } state_type;

   localparam state_type STATE_RESET = '{
      scan_mode:       MODE_NORMAL,
      open_quote:      QUOTE_NONE,
      last_emitted:    8'h00,
      any_emitted:     1'b0,
      decode_acc:      '0,
      bytes_remaining: 2'd0,
      sequence_length: 3'd0,
      cr_pending:      1'b0,
      failed:          1'b0
   };

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_has_char;
      logic       out_error;
      logic       out_last;
   } result_type;

   typedef result_type [RES_SLOTS-1:0] result_vec_type;

   // Outcome of one request: the next scanner state and its group of results.
   typedef struct packed {
      state_type      s;
      result_vec_type r;
      logic [1:0]     n;
   } work_type;

   function automatic cp_type utf8_offset(input logic [2:0] len);
      cp_type off;
      unique case (len)
         3'd2:    off = 26'h0003080;
         3'd3:    off = 26'h00E2080;
         3'd4:    off = 26'h3C82080;
         default: off = '0;
      endcase
      return off;
   endfunction

   function automatic cp_type quote_char(input logic [1:0] q);
      cp_type ch;
      unique case (q)
         QUOTE_SINGLE:   ch = CP_SQUOTE;
         QUOTE_DOUBLE:   ch = CP_DQUOTE;
         QUOTE_BACKTICK: ch = CP_BACKTICK;
         default:        ch = '0;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/source_comment_stripper_core.sv
// Top level of the source comment stripper: request register, scan step and result queue.
// A request is registered, scanned by the scan step, and its result group is registered
// into the result queue, which drives rsp_.
// Throughput: one request per cycle while each request gives at most one result and rsp_ready
// is high; more results hold the scan stage while the group drains one a cycle on rsp_ready.
// Reset (synchronous): both settings return to 1 and the scanner returns to plain text.
module source_comment_stripper_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_has_char,
   output logic       rsp_out_error,
   output logic       rsp_out_last
);
   import scs_pkg::*;

   logic           utf8_ff, strip_ff;
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   state_type      state_ff;
   result_vec_type grp_ff;
   logic [1:0]     grp_cnt_ff, grp_ptr_ff, grp_ptr_in;
   work_type       step;
   logic           drain_done, advance;
   result_type     cur;

   scs_step u_step (
      .st             (state_ff),
      .source_is_utf8 (utf8_ff),
      .strip_comments (strip_ff),
      .in_byte        (in_byte_ff),
      .in_last        (in_last_ff),
      .step           (step)
   );

   assign rsp_valid  = (grp_ptr_ff != grp_cnt_ff);
   assign grp_ptr_in = 2'(grp_ptr_ff + 2'd1);
   // The group slot is free when it is empty or once its last result leaves in this cycle.
   assign drain_done = !rsp_valid || (rsp_ready && grp_ptr_in == grp_cnt_ff);
   assign advance    = in_valid_ff && drain_done;
   assign req_ready  = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   assign cur              = grp_ff[grp_ptr_ff];
   assign rsp_out_char     = cur.out_char;
   assign rsp_out_has_char = cur.out_has_char;
   assign rsp_out_error    = cur.out_error;
   assign rsp_out_last     = cur.out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_ff  <= 1'b1;
         strip_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_IS_UTF8: utf8_ff  <= csr_wdata;
            CSR_STRIP_COMMENTS: strip_ff <= csr_wdata;
            default:            utf8_ff  <= utf8_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         grp_cnt_ff  <= 2'd0;
         grp_ptr_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff   <= step.s;
            grp_cnt_ff <= step.n;
            grp_ptr_ff <= 2'd0;
         end else if (rsp_valid && rsp_ready) begin
            grp_ptr_ff <= grp_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
      if (advance) begin
         grp_ff <= step.r;
      end
   end

endmodule

FILE: rtl/scs_step.sv
// Combinational decode and comment scan of one registered source byte.
module scs_step (
   input  scs_pkg::state_type st,
   input  logic               source_is_utf8,
   input  logic               strip_comments,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   output scs_pkg::work_type  step
);
   import scs_pkg::*;

   function automatic work_type push(input work_type w, input logic [7:0] ch,
                                     input logic has, input logic err);
      work_type o;
      o = w;
      if (o.n != 2'(MAX_RES)) begin
         o.r[o.n] = '{out_char: ch, out_has_char: has, out_error: err, out_last: err};
         o.n      = 2'(o.n + 2'd1);
      end
      return o;
   endfunction

   function automatic work_type put(input work_type w, input logic [7:0] ch);
      work_type o;
      o = w;
      if (!o.s.failed) begin
         o = push(o, ch, 1'b1, 1'b0);
         o.s.last_emitted = ch;
         o.s.any_emitted  = 1'b1;
      end
      return o;
   endfunction

   function automatic work_type keep(input work_type w, input cp_type c);
      work_type o;
      o = w;
      if (!o.s.failed) begin
         if (|c[CP_W-1:8]) begin
            o          = push(o, 8'h00, 1'b0, 1'b1);
            o.s.failed = 1'b1;
         end else begin
            o = put(o, c[7:0]);
         end
      end
      return o;
   endfunction

   function automatic logic is_term(input cp_type c);
      return (c == CP_CR) || (c == CP_LF) || (c == CP_LS) || (c == CP_PS);
   endfunction

   function automatic work_type string_char(input work_type w, input cp_type c);
      work_type o;
      o = keep(w, c);
      if (!o.s.failed) begin
         if (c == quote_char(o.s.open_quote)) o.s.scan_mode = MODE_NORMAL;
         else if (c == CP_BACKSLASH)           o.s.scan_mode = MODE_ESC;
      end
      return o;
   endfunction

   function automatic work_type normal_char(input work_type w, input cp_type c);
      work_type o;
      o = w;
      if (c == CP_SQUOTE || c == CP_DQUOTE || c == CP_BACKTICK) begin
         if (c == CP_SQUOTE)      o.s.open_quote = QUOTE_SINGLE;
         else if (c == CP_DQUOTE) o.s.open_quote = QUOTE_DOUBLE;
         else                     o.s.open_quote = QUOTE_BACKTICK;
         o.s.scan_mode = MODE_STRING;
         o = put(o, c[7:0]);
      end else if (c == CP_SLASH) begin
         o.s.scan_mode = MODE_SLASH;
      end else begin
         o = keep(o, c);
      end
      return o;
   endfunction

   // Inside a block comment every line terminator becomes one LF.
   function automatic work_type block_body(input work_type w, input cp_type c);
      work_type o;
      o = w;
      if (c == CP_STAR) begin
         o.s.scan_mode = MODE_BSTAR;
      end else if (c == CP_CR) begin
         o = put(o, CH_LF);
         o.s.cr_pending = 1'b1;
      end else if (is_term(c)) begin
         o = put(o, CH_LF);
      end
      return o;
   endfunction

   function automatic work_type scan_char(input work_type w, input cp_type c);
      work_type o;
      o = w;
      unique case (o.s.scan_mode)
         MODE_SLASH: begin
            o.s.scan_mode = MODE_NORMAL;
            if (c == CP_SLASH &&
                (!o.s.any_emitted || o.s.last_emitted != CH_BACKSLASH)) begin
               o.s.scan_mode  = MODE_LINE;
               o.s.cr_pending = 1'b0;
            end else if (c == CP_STAR) begin
               o.s.scan_mode  = MODE_BLOCK;
               o.s.cr_pending = 1'b0;
            end else begin
               o = put(o, CH_SLASH);
               o = keep(o, c);
            end
         end
         MODE_LINE: begin
            if (o.s.cr_pending) begin
               o.s.cr_pending = 1'b0;
               o.s.scan_mode  = MODE_NORMAL;
               if (c == CP_LF) begin
                  o = put(o, CH_LF);
               end else begin
                  o = put(o, CH_CR);
                  o = normal_char(o, c);
               end
            end else if (c == CP_CR) begin
               o.s.cr_pending = 1'b1;
            end else if (is_term(c)) begin
               o.s.scan_mode = MODE_NORMAL;
               o = keep(o, c);
            end
         end
         MODE_BLOCK: begin
            if (o.s.cr_pending && c == CP_LF) begin
               o.s.cr_pending = 1'b0;
            end else begin
               o.s.cr_pending = 1'b0;
               o = block_body(o, c);
            end
         end
         MODE_BSTAR: begin
            if (c == CP_SLASH) begin
               o.s.scan_mode = MODE_NORMAL;
            end else if (c != CP_STAR) begin
               o.s.scan_mode = MODE_BLOCK;
               o = block_body(o, c);
            end
         end
         MODE_STRING: begin
            o = string_char(o, c);
         end
         MODE_ESC: begin
            o.s.scan_mode = MODE_STRING;
            if (c == quote_char(o.s.open_quote) || c == CP_BACKSLASH) o = put(o, c[7:0]);
            else o = string_char(o, c);
         end
         default: begin
            o.s.scan_mode = MODE_NORMAL;
            o = normal_char(o, c);
         end
      endcase
      return o;
   endfunction

   always_comb begin
      work_type   w;
      logic       have;
      cp_type     c;
      logic [2:0] len;
      w.s  = st;
      w.r  = '0;
      w.n  = 2'd0;
      have = 1'b0;
      c    = '0;
      len  = 3'd1;
      if (st.failed) begin
         if (in_last) w.s = STATE_RESET;
      end else begin
         if (!source_is_utf8) begin
            w.s.bytes_remaining = 2'd0;
            c    = CP_W'(in_byte);
            have = 1'b1;
         end else if (st.bytes_remaining != 2'd0) begin
            w.s.decode_acc      = CP_W'({st.decode_acc, 6'd0}) + CP_W'(in_byte);
            w.s.bytes_remaining = 2'(st.bytes_remaining - 2'd1);
            if (w.s.bytes_remaining == 2'd0) begin
               c    = w.s.decode_acc - utf8_offset(st.sequence_length);
               have = 1'b1;
            end
         end else begin
            priority if (in_byte[7:5] == 3'b110)  len = 3'd2;
            else if (in_byte[7:4] == 4'b1110)    len = 3'd3;
            else if (in_byte[7:3] == 5'b11110)   len = 3'd4;
            else                                 len = 3'd1;
            if (len == 3'd1) begin
               c    = CP_W'(in_byte);
               have = 1'b1;
            end else begin
               w.s.decode_acc      = CP_W'(in_byte);
               w.s.sequence_length = len;
               w.s.bytes_remaining = 2'(len - 3'd1);
            end
         end

         if (have) begin
            if (strip_comments) w = scan_char(w, c);
            else                w = keep(w, c);
         end

         if (in_last) begin
            if (!w.s.failed) begin
               if (w.s.scan_mode == MODE_SLASH) begin
                  w = put(w, CH_SLASH);
               end else if (w.s.scan_mode == MODE_LINE && w.s.cr_pending) begin
                  w = put(w, CH_CR);
               end
            end
            if (w.n == 2'd0) begin
               w.r[0] = '{out_char: 8'h00, out_has_char: 1'b0, out_error: 1'b0,
                          out_last: 1'b1};
               w.n    = 2'd1;
            end else begin
               w.r[2'(w.n - 2'd1)].out_last = 1'b1;
            end
            w.s = STATE_RESET;
         end
      end
      step = w;
   end

endmodule
